[hw/rtl/moa_pkg.sv]
// ----------------------------------------------------------------------------
// moa_pkg: shared types and constants for the oversampling averager
// Field widths, register map codes, config and control structs.
// ----------------------------------------------------------------------------
package moa_pkg;

    // default build parameters
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 10;
    localparam int ACCUM_BITS_DEF   = 20;

    // fixed field widths
    localparam int NUM_CH_W  = 5;
    localparam int SET_W     = 11;
    localparam int SHIFT_W   = 4;
    localparam int CHAN_W    = 4;
    localparam int AVG_W     = 16;
    localparam int UPD_W     = 8;

    // APB
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register reset values
    localparam logic [NUM_CH_W-1:0] NUM_CH_RST = 5'd16;
    localparam logic [SET_W-1:0]    SET_RST    = 11'd8;
    localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 4'd3;

    typedef enum logic [1:0] {
        REG_NUM_CHANNELS    = 2'd0,
        REG_SAMPLES_PER_SET = 2'd1,
        REG_RESULT_SHIFT    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_CH_W-1:0] num_channels;
        logic [SET_W-1:0]    samples_per_set;
        logic [SHIFT_W-1:0]  result_shift;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic take;       // input may be accepted
        logic load_out;   // load result for current flush index
        logic clear_acc;  // zero all accumulators
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic flush_req;  // accepted request completed a set
        logic out_free;   // output register can take a result
        logic idx_last;   // flush index is the final active channel
    } t_dp_status;

endpackage

[hw/rtl/moa_chan_if.sv]
// ----------------------------------------------------------------------------
// moa channel interfaces
// Valid/ready channels for conversion requests and averaged results.
// ----------------------------------------------------------------------------
interface moa_in_if
    import moa_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   clear_count;

    modport source (output valid, output sample, output clear_count, input ready);
    modport sink   (input valid, input sample, input clear_count, output ready);
endinterface

interface moa_out_if
    import moa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_channel;
    logic [AVG_W-1:0]  average;
    logic              last;
    logic [UPD_W-1:0]  update_count;

    modport source (output valid, output out_channel, output average, output last,
                    output update_count, input ready);
    modport sink   (input valid, input out_channel, input average, input last,
                    input update_count, output ready);
endinterface

[hw/rtl/moa_ctrl.sv]
// ----------------------------------------------------------------------------
// moa_ctrl: sequencing controller
// Accepts requests while idle; walks the flush of one result per channel.
// ----------------------------------------------------------------------------
module moa_ctrl
    import moa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take = 1'b1;
                if (i_st.flush_req) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_st.idx_last) begin
                        o_cmd.clear_acc = 1'b1;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/moa_datapath.sv]
// ----------------------------------------------------------------------------
// moa_datapath: accumulators, channel/set counters and result register
// Saturating per-channel accumulate, set tracking, shift/saturate readout.
// ----------------------------------------------------------------------------
module moa_datapath
    import moa_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int ACCUM_BITS   = ACCUM_BITS_DEF
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_st,
    moa_in_if.sink     i_adc,
    moa_out_if.source  o_res
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [32:0]         ACC_MAX = (33'd1 << ACCUM_BITS) - 33'd1;
    localparam logic [NUM_CH_W-1:0] MAX_N   = NUM_CH_W'(MAX_CHANNELS);

    logic [ACCUM_BITS-1:0] r_acc [MAX_CHANNELS];
    logic [CH_W-1:0]       r_ch;
    logic [CH_W-1:0]       r_idx;
    logic [SET_W-1:0]      r_sc;
    logic [UPD_W-1:0]      r_sd;
    logic                  r_out_valid;
    logic [CHAN_W-1:0]     r_out_ch;
    logic [AVG_W-1:0]      r_out_avg;
    logic                  r_out_last;
    logic [UPD_W-1:0]      r_out_upd;

    logic [NUM_CH_W-1:0]   w_n;
    logic                  w_take;
    logic [32:0]           w_sum;
    logic [ACCUM_BITS-1:0] w_acc_new;
    logic [NUM_CH_W-1:0]   w_ch_inc;
    logic                  w_wrap;
    logic [CH_W-1:0]       w_ch_next;
    logic [SET_W-1:0]      w_sc_inc;
    logic                  w_flush;
    logic [UPD_W-1:0]      w_sd_base;
    logic [31:0]           w_shifted;
    logic [AVG_W-1:0]      w_avg;

    // zero channels acts as one; above the build limit clamps
    always_comb begin
        if (i_cfg.num_channels == '0) begin
            w_n = NUM_CH_W'(1);
        end else if (i_cfg.num_channels > MAX_N) begin
            w_n = MAX_N;
        end else begin
            w_n = i_cfg.num_channels;
        end
    end

    assign i_adc.ready = i_cmd.take;
    assign w_take      = i_adc.valid && i_cmd.take;

    assign w_sum     = 33'(r_acc[r_ch]) + 33'(i_adc.sample[SAMPLE_BITS-1:0]);
    assign w_acc_new = (w_sum > ACC_MAX) ? ACC_MAX[ACCUM_BITS-1:0] : w_sum[ACCUM_BITS-1:0];

    assign w_ch_inc  = NUM_CH_W'(r_ch) + NUM_CH_W'(1);
    assign w_wrap    = (w_ch_inc >= w_n);
    assign w_ch_next = w_wrap ? '0 : CH_W'(w_ch_inc);
    assign w_sc_inc  = (w_wrap && (r_sc != '1)) ? r_sc + SET_W'(1) : r_sc;
    assign w_flush   = (w_sc_inc >= i_cfg.samples_per_set);
    assign w_sd_base = i_adc.clear_count ? '0 : r_sd;

    assign w_shifted = 32'(r_acc[r_idx]) >> i_cfg.result_shift;
    assign w_avg     = (|w_shifted[31:AVG_W]) ? '1 : w_shifted[AVG_W-1:0];

    assign o_st.flush_req = w_take && w_flush;
    assign o_st.out_free  = !r_out_valid || o_res.ready;
    assign o_st.idx_last  = ((NUM_CH_W'(r_idx) + NUM_CH_W'(1)) == w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                r_acc[k] <= '0;
            end
            r_ch        <= '0;
            r_idx       <= '0;
            r_sc        <= '0;
            r_sd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_acc[r_ch] <= w_acc_new;
                r_ch        <= w_ch_next;
                r_sc        <= w_flush ? '0 : w_sc_inc;
                r_sd        <= w_flush ? w_sd_base + UPD_W'(1) : w_sd_base;
            end
            if (i_cmd.load_out) begin
                r_idx       <= o_st.idx_last ? '0 : r_idx + CH_W'(1);
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            // last result is being loaded; start the next set from zero
            if (i_cmd.clear_acc) begin
                for (int k = 0; k < MAX_CHANNELS; k++) begin
                    r_acc[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_ch   <= CHAN_W'(r_idx);
            r_out_avg  <= w_avg;
            r_out_last <= o_st.idx_last;
            r_out_upd  <= r_sd;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_channel  = r_out_ch;
    assign o_res.average      = r_out_avg;
    assign o_res.last         = r_out_last;
    assign o_res.update_count = r_out_upd;

endmodule

[hw/rtl/multichannel_oversample_averager.sv]
// ----------------------------------------------------------------------------
// multichannel_oversample_averager: round-robin ADC oversampling averager
// Sums conversions per channel and emits one average per channel per set.
// ----------------------------------------------------------------------------
// Usage:
//   i_adc takes one conversion request per handshake; the sample goes to the
//   current channel and the channel index steps round-robin. o_res carries
//   averaged results, one per active channel in channel order, last set on
//   the highest channel. APB config (0x0 num_channels, 0x4 samples_per_set,
//   0x8 result_shift) must be written only while idle; the block doesn't check.
// Flow:
//   A request that does not complete a set leaves i_adc.ready high. One that
//   completes a set starts a flush of N results, N the active channel count:
//   the sequencer loads one result per cycle into the single output register,
//   which is the limit, while that is free. The first result follows the
//   state register, then the output register. No input is taken in the flush.
// Reset and stall:
//   Synchronous reset clears accumulators, counters and the output valid;
//   config returns to 16 channels, 8 sweeps, shift 3. When o_res.ready is
//   low the flush waits on the output register; no result is dropped.
// ----------------------------------------------------------------------------
module multichannel_oversample_averager
    import moa_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int ACCUM_BITS   = ACCUM_BITS_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    moa_in_if.sink                i_adc,
    moa_out_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg       r_cfg;
    t_dp_cmd    w_cmd;
    t_dp_status w_st;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_channels    <= NUM_CH_RST;
            r_cfg.samples_per_set <= SET_RST;
            r_cfg.result_shift    <= SHIFT_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_NUM_CHANNELS:    r_cfg.num_channels    <= pwdata[NUM_CH_W-1:0];
                REG_SAMPLES_PER_SET: r_cfg.samples_per_set <= pwdata[SET_W-1:0];
                REG_RESULT_SHIFT:    r_cfg.result_shift    <= pwdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_NUM_CHANNELS:    prdata = APB_DATA_W'(r_cfg.num_channels);
            REG_SAMPLES_PER_SET: prdata = APB_DATA_W'(r_cfg.samples_per_set);
            REG_RESULT_SHIFT:    prdata = APB_DATA_W'(r_cfg.result_shift);
            default:             prdata = '0;
        endcase
    end

    moa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    moa_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .ACCUM_BITS   (ACCUM_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (w_cmd),
        .o_st    (w_st),
        .i_adc   (i_adc),
        .o_res   (o_res)
    );

`ifndef SYNTH
    // a set-completing request blocks further input for the flush
    a_flush_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adc.valid && i_adc.ready && w_st.flush_req) |=> !i_adc.ready)
        else $error("input accepted during flush");

    // every load shows up as a valid result
    a_load_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> o_res.valid)
        else $error("loaded result not presented");

    // final load marks last and reopens the input
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_out && w_st.idx_last) |=> (o_res.last && i_adc.ready))
        else $error("flush end mismatch");

    // no load while a stalled result still sits in the output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !w_cmd.load_out)
        else $error("pending result overwritten");
`endif

endmodule

[tb/multichannel_oversample_averager_tb.sv]
// ----------------------------------------------------------------------------
// multichannel_oversample_averager_tb: self-checking bench for the averager
// Streams conversion requests through a randomly gapped driver, predicts each
// flush with an in-bench model of the per-channel sums, and checks every
// averaged result field by field as the stalling monitor takes it.
// ----------------------------------------------------------------------------
module multichannel_oversample_averager_tb;
    import moa_pkg::*;

    localparam int SMP_W       = SAMPLE_BITS_DEF;
    localparam int ACC_W       = ACCUM_BITS_DEF;
    localparam int MAX_CH      = MAX_CHANNELS_DEF;
    localparam int WDOG_LIMIT  = 3000;
    localparam int RX_HOLD_LEN = 300;
    localparam int RAND_ITEMS  = 280;

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             clear;
    } t_conversion;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [AVG_W-1:0]  avg;
        logic              last;
        logic [UPD_W-1:0]  upd;
    } t_avg_result;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    moa_in_if  adc_if ();
    moa_out_if res_if ();

    multichannel_oversample_averager u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adc   (adc_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // stimulus and scoreboard
    t_conversion pending_conversions[$];
    t_avg_result expected_avgs[$];
    int          err_cnt   = 0;
    bit          adc_busy  = 1'b0;
    int          tx_gap    = 0;
    int          rx_stall  = 0;
    int          rx_hold_left = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    bit          tx_burst  = 1'b0;
    bit          rx_burst  = 1'b0;
    int          idle_cycles = 0;

    // predicted block state
    logic [ACC_W-1:0]    chan_sum [MAX_CH];
    logic [CHAN_W-1:0]   scan_ch     = '0;
    logic [SET_W-1:0]    sweep_cnt   = '0;
    logic [UPD_W-1:0]    set_updates = '0;
    logic [NUM_CH_W-1:0] nch_reg     = NUM_CH_RST;
    logic [SET_W-1:0]    sps_reg     = SET_RST;
    logic [SHIFT_W-1:0]  shift_reg   = SHIFT_RST;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned scanned_channels(logic [NUM_CH_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_CH)
            return MAX_CH;
        return raw;
    endfunction

    // add one conversion to the running sums; queue the flush if the set closes
    function automatic void accumulate_sample(logic [SMP_W-1:0] smp, logic clr);
        int unsigned      n;
        int unsigned      nxt;
        logic [ACC_W:0]   sum;
        logic [ACC_W-1:0] q;
        t_avg_result      r;
        n = scanned_channels(nch_reg);
        if (clr)
            set_updates = '0;
        sum = {1'b0, chan_sum[scan_ch]} + smp;
        chan_sum[scan_ch] = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        nxt = scan_ch + 1;
        if (nxt >= n) begin
            nxt = 0;
            if (sweep_cnt != '1)
                sweep_cnt = sweep_cnt + 1'b1;
        end
        scan_ch = nxt[CHAN_W-1:0];
        if (sweep_cnt >= sps_reg) begin
            set_updates = set_updates + 1'b1;
            for (int i = 0; i < n; i++) begin
                q      = chan_sum[i] >> shift_reg;
                r.chan = i[CHAN_W-1:0];
                r.avg  = (q > 65535) ? '1 : q[AVG_W-1:0];
                r.last = (i + 1 == n);
                r.upd  = set_updates;
                expected_avgs.push_back(r);
            end
            for (int i = 0; i < MAX_CH; i++)
                chan_sum[i] = '0;
            sweep_cnt = '0;
        end
    endfunction

    // driver: one request in flight, random gap drawn after each accept
    always @(posedge i_clk) begin
        t_conversion nxt_conv;
        if (!i_rst_n) begin
            adc_if.valid <= 1'b0;
            adc_busy = 1'b0;
            tx_gap   = 0;
        end else begin
            if (adc_busy && adc_if.ready) begin
                accumulate_sample(adc_if.sample, adc_if.clear_count);
                adc_busy = 1'b0;
                tx_gap   = tx_burst ? 0 : $urandom_range(0, 9);
            end
            if (!adc_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_conversions.size() > 0) begin
                    nxt_conv = pending_conversions.pop_front();
                    adc_if.sample      <= nxt_conv.sample;
                    adc_if.clear_count <= nxt_conv.clear;
                    adc_busy = 1'b1;
                end
            end
            adc_if.valid <= adc_busy;
        end
    end

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            err_cnt++;
            if (err_cnt < 40)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v,
                         act_v);
        end
    endtask

    // monitor: checks each result, stalls per result and on hold requests
    always @(posedge i_clk) begin
        t_avg_result exp_r;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_stall     = 0;
            rx_hold_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_avgs.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result: expected none, got ch %0d avg %0d",
                             $time, res_if.out_channel, res_if.average);
                end else begin
                    exp_r = expected_avgs.pop_front();
                    check_field("out_channel", exp_r.chan, res_if.out_channel);
                    check_field("average", exp_r.avg, res_if.average);
                    check_field("last", exp_r.last, res_if.last);
                    check_field("update_count", exp_r.upd, res_if.update_count);
                end
                rx_stall = rx_burst ? 0 : $urandom_range(0, 9);
            end
            if (hold_reqs != hold_seen) begin
                hold_seen    = hold_reqs;
                rx_hold_left = RX_HOLD_LEN;
            end
            if (rx_hold_left > 0)
                rx_hold_left--;
            else if (rx_stall > 0)
                rx_stall--;
            res_if.ready <= (rx_hold_left == 0) && (rx_stall == 0);
        end
    end

    // watchdog on cycles with no request or result accepted
    always @(posedge i_clk) begin
        if ((adc_if.valid && adc_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_avgs.size());
            $display("multichannel_oversample_averager_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic cfg_write(t_reg_idx idx, logic [APB_DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NUM_CHANNELS:    nch_reg   = val[NUM_CH_W-1:0];
            REG_SAMPLES_PER_SET: sps_reg   = val[SET_W-1:0];
            REG_RESULT_SHIFT:    shift_reg = val[SHIFT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned nch, int unsigned sps, int unsigned shift);
        cfg_write(REG_NUM_CHANNELS, nch);
        cfg_write(REG_SAMPLES_PER_SET, sps);
        cfg_write(REG_RESULT_SHIFT, shift);
    endtask

    // sender pause: everything sent and every predicted result taken
    task automatic wait_idle();
        while (pending_conversions.size() != 0 || adc_busy || expected_avgs.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic void push_conv(logic [SMP_W-1:0] smp, logic clr);
        t_conversion c;
        c.sample = smp;
        c.clear  = clr;
        pending_conversions.push_back(c);
    endfunction

    function automatic void push_random(int count);
        logic [SMP_W-1:0] smp;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    smp = '1;
                2:       smp = '0;
                default: smp = SMP_W'($urandom);
            endcase
            push_conv(smp, $urandom_range(0, 9) == 0);
        end
    endfunction

    initial begin
        int unsigned nch;
        int unsigned sps;
        int unsigned n_eff;
        int          count;
        int          rand_sent;
        for (int i = 0; i < MAX_CH; i++)
            chan_sum[i] = '0;
        adc_if.valid       = 1'b0;
        adc_if.sample      = '0;
        adc_if.clear_count = 1'b0;
        res_if.ready       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero channel count acts as one; set size zero flushes every request
        set_config(0, 0, 0);
        push_conv('1, 1'b0);
        push_conv('0, 1'b1);
        push_conv('1, 1'b0);
        wait_idle();

        // oversized channel count clamps to 16; shift of fifteen
        set_config(31, 1, 15);
        for (int i = 0; i < MAX_CH; i++)
            push_conv((i % 2) ? SMP_W'(10'h2AA) : '1, 1'b0);
        wait_idle();

        // channel count lowered mid-set: index wraps, unscanned sums cleared
        set_config(16, 1, 0);
        for (int i = 0; i < 5; i++)
            push_conv('1, 1'b0);
        wait_idle();
        cfg_write(REG_NUM_CHANNELS, 2);
        push_conv(SMP_W'(10'h155), 1'b0);
        wait_idle();

        // set size above 1024 holds the set open; a smaller size then closes it
        tx_burst <= 1'b1;
        rx_burst <= 1'b1;
        set_config(1, 1100, 5);
        for (int i = 0; i < 24; i++)
            push_conv('1, 1'b0);
        wait_idle();
        cfg_write(REG_SAMPLES_PER_SET, 3);
        push_conv('1, 1'b0);
        wait_idle();

        // long receiver hold while the sender keeps offering
        tx_burst <= 1'b1;
        rx_burst <= 1'b0;
        set_config(4, 1, 2);
        hold_reqs <= hold_reqs + 1;
        push_random(40);
        rand_sent = 40;
        wait_idle();

        while (rand_sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       nch = 0;
                1:       nch = 31;
                2:       nch = 16;
                3:       nch = 1;
                default: nch = $urandom_range(1, 16);
            endcase
            sps = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
            n_eff = scanned_channels(nch);
            count = n_eff * ((sps == 0) ? 1 : sps) * $urandom_range(1, 2)
                    + $urandom_range(0, n_eff - 1);
            if (count > 80)
                count = 80;
            tx_burst <= ($urandom_range(0, 3) == 0);
            rx_burst <= ($urandom_range(0, 3) == 0);
            set_config(nch, sps, $urandom_range(0, 15));
            push_random(count);
            rand_sent += count;
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && expected_avgs.size() == 0) begin
            $display("multichannel_oversample_averager_tb: PASS");
        end else begin
            $display("%0t: %0d mismatches, %0d results never seen", $time, err_cnt,
                     expected_avgs.size());
            $display("multichannel_oversample_averager_tb: FAIL");
        end
        $finish;
    end

endmodule
